>>> rtl/gvr_pkg.sv
// ----------------------------------------------------------------------------
// gvr_pkg
// Shared widths and the item record that travels down the Givens rotation
// pipeline.
// ----------------------------------------------------------------------------
package gvr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TRIG_FRAC  = 30;

  localparam int SUM_W  = 2 * DATA_WIDTH;
  localparam int TRIG_W = TRIG_FRAC + 2;
  localparam int CQ_W   = TRIG_FRAC + 1;
  localparam int RQ_W   = FRAC_BITS + TRIG_FRAC + 1;
  localparam int ZW     = ((RQ_W > DATA_WIDTH) ? RQ_W : DATA_WIDTH) + 1;

  localparam int SQRT_STEPS  = DATA_WIDTH;
  localparam int DIV_STEPS   = TRIG_FRAC;
  localparam int RECIP_STEPS = FRAC_BITS + TRIG_FRAC;

  typedef struct packed {
    logic                  aneg;
    logic                  bneg;
    logic                  zero;
    logic                  a_gt_b;
    logic [DATA_WIDTH-1:0] amag;
    logic [DATA_WIDTH-1:0] bmag;
    logic [SUM_W-1:0]      sq_bits;
    logic [SUM_W-1:0]      bsq;
    logic [DATA_WIDTH:0]   sq_rem;
    logic [DATA_WIDTH-1:0] root;
    logic                  rneg;
    logic                  cneg;
    logic                  sneg;
    logic [DATA_WIDTH-1:0] c_rem;
    logic [DATA_WIDTH-1:0] s_rem;
    logic [CQ_W-1:0]       c_q;
    logic [CQ_W-1:0]       s_q;
    logic                  z_from_s;
    logic                  z_one;
    logic [CQ_W-1:0]       z_rem;
    logic [RQ_W-1:0]       z_q;
  } gvr_item_t;

endpackage

>>> rtl/gvr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gvr_sqrt_cell
// One digit step of the integer square root: two radicand bits in, one root
// bit out.
// ----------------------------------------------------------------------------
module gvr_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  gvr_pkg::gvr_item_t in_item,
  output logic               out_valid,
  output gvr_pkg::gvr_item_t out_item
);

  logic [gvr_pkg::DATA_WIDTH+2:0] rem2;
  logic [gvr_pkg::DATA_WIDTH+2:0] trial;
  gvr_pkg::gvr_item_t             item_nxt;
  gvr_pkg::gvr_item_t             item_r;
  logic                           valid_r;

  always_comb begin
    item_nxt = in_item;
    rem2     = {in_item.sq_rem, in_item.sq_bits[gvr_pkg::SUM_W-1 -: 2]};
    trial    = {1'b0, in_item.root, 2'b01};
    item_nxt.sq_bits = {in_item.sq_bits[gvr_pkg::SUM_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      item_nxt.sq_rem = (gvr_pkg::DATA_WIDTH+1)'(rem2 - trial);
      item_nxt.root   = {in_item.root[gvr_pkg::DATA_WIDTH-2:0], 1'b1};
    end else begin
      item_nxt.sq_rem = (gvr_pkg::DATA_WIDTH+1)'(rem2);
      item_nxt.root   = {in_item.root[gvr_pkg::DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> rtl/gvr_div_cell.sv
// ----------------------------------------------------------------------------
// gvr_div_cell
// One restoring division step for the cosine and sine lanes side by side.
// ----------------------------------------------------------------------------
module gvr_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  gvr_pkg::gvr_item_t in_item,
  output logic               out_valid,
  output gvr_pkg::gvr_item_t out_item
);

  logic [gvr_pkg::DATA_WIDTH:0] c_rem2;
  logic [gvr_pkg::DATA_WIDTH:0] s_rem2;
  logic [gvr_pkg::DATA_WIDTH:0] den;
  gvr_pkg::gvr_item_t           item_nxt;
  gvr_pkg::gvr_item_t           item_r;
  logic                         valid_r;

  always_comb begin
    item_nxt = in_item;
    c_rem2   = {in_item.c_rem, 1'b0};
    s_rem2   = {in_item.s_rem, 1'b0};
    den      = {1'b0, in_item.root};
    if (c_rem2 >= den) begin
      item_nxt.c_rem = gvr_pkg::DATA_WIDTH'(c_rem2 - den);
      item_nxt.c_q   = {in_item.c_q[gvr_pkg::CQ_W-2:0], 1'b1};
    end else begin
      item_nxt.c_rem = gvr_pkg::DATA_WIDTH'(c_rem2);
      item_nxt.c_q   = {in_item.c_q[gvr_pkg::CQ_W-2:0], 1'b0};
    end
    if (s_rem2 >= den) begin
      item_nxt.s_rem = gvr_pkg::DATA_WIDTH'(s_rem2 - den);
      item_nxt.s_q   = {in_item.s_q[gvr_pkg::CQ_W-2:0], 1'b1};
    end else begin
      item_nxt.s_rem = gvr_pkg::DATA_WIDTH'(s_rem2);
      item_nxt.s_q   = {in_item.s_q[gvr_pkg::CQ_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> rtl/gvr_recip_cell.sv
// ----------------------------------------------------------------------------
// gvr_recip_cell
// One restoring division step of the reciprocal of the cosine.
// ----------------------------------------------------------------------------
module gvr_recip_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  gvr_pkg::gvr_item_t in_item,
  output logic               out_valid,
  output gvr_pkg::gvr_item_t out_item
);

  logic [gvr_pkg::CQ_W:0] rem2;
  logic [gvr_pkg::CQ_W:0] den;
  gvr_pkg::gvr_item_t     item_nxt;
  gvr_pkg::gvr_item_t     item_r;
  logic                   valid_r;

  always_comb begin
    item_nxt = in_item;
    rem2     = {in_item.z_rem, 1'b0};
    den      = {1'b0, in_item.c_q};
    if (rem2 >= den) begin
      item_nxt.z_rem = gvr_pkg::CQ_W'(rem2 - den);
      item_nxt.z_q   = {in_item.z_q[gvr_pkg::RQ_W-2:0], 1'b1};
    end else begin
      item_nxt.z_rem = gvr_pkg::CQ_W'(rem2);
      item_nxt.z_q   = {in_item.z_q[gvr_pkg::RQ_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> rtl/givens_rotation_generate.sv
// ----------------------------------------------------------------------------
// givens_rotation_generate
// Fixed-point plane rotation generator: radius, cosine, sine and the
// reconstruction value for each (a, b) pair.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  a_value, b_value (Q16.16)
//  out_     output     out_valid/out_stall radius, cos_val, sin_val, recon_z,
//                                         z_saturated
//
//  One item is accepted per cycle while in_stall is low. Each item passes the
//  input, magnitude and square registers, the square-root cells, a division
//  setup register, the division cells, a reciprocal setup register, the
//  reciprocal cells and the output register; each cell resolves one result bit.
//  Reset clears all valid flags; payload registers are not reset.
//  A stalled output freezes the whole chain and raises in_stall in the same
//  cycle.
// ----------------------------------------------------------------------------
module givens_rotation_generate (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gvr_pkg::DATA_WIDTH-1:0] in_a_value,
  input  logic signed [gvr_pkg::DATA_WIDTH-1:0] in_b_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gvr_pkg::DATA_WIDTH:0]   out_radius,
  output logic signed [gvr_pkg::TRIG_W-1:0]     out_cos_val,
  output logic signed [gvr_pkg::TRIG_W-1:0]     out_sin_val,
  output logic signed [gvr_pkg::DATA_WIDTH-1:0] out_recon_z,
  output logic                               out_z_saturated
);

  localparam int DW = gvr_pkg::DATA_WIDTH;

  logic en;

  // Input capture
  logic          s0_valid_r;
  logic [DW-1:0] s0_a_r;
  logic [DW-1:0] s0_b_r;

  // Magnitudes and squares
  gvr_pkg::gvr_item_t s1_nxt, s1_r;
  logic               s1_valid_r;
  gvr_pkg::gvr_item_t s2_nxt, s2_r;
  logic               s2_valid_r;

  gvr_pkg::gvr_item_t sq_item  [0:gvr_pkg::SQRT_STEPS];
  logic               sq_valid [0:gvr_pkg::SQRT_STEPS];
  gvr_pkg::gvr_item_t dv_item  [0:gvr_pkg::DIV_STEPS];
  logic               dv_valid [0:gvr_pkg::DIV_STEPS];
  gvr_pkg::gvr_item_t rc_item  [0:gvr_pkg::RECIP_STEPS];
  logic               rc_valid [0:gvr_pkg::RECIP_STEPS];

  gvr_pkg::gvr_item_t di_nxt, di_r;
  logic               di_valid_r;
  gvr_pkg::gvr_item_t ri_nxt, ri_r;
  logic               ri_valid_r;

  logic                       out_valid_r;
  logic [DW:0]                radius_r, radius_nxt;
  logic [gvr_pkg::TRIG_W-1:0] cos_r, cos_nxt;
  logic [gvr_pkg::TRIG_W-1:0] sin_r, sin_nxt;
  logic [DW-1:0]              z_r, z_nxt;
  logic                       sat_r, sat_nxt;

  gvr_pkg::gvr_item_t         fin;
  logic [gvr_pkg::ZW-1:0]     zmag;
  logic                       zneg;
  logic [gvr_pkg::ZW-1:0]     posmax;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      di_valid_r  <= 1'b0;
      ri_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r  <= in_valid;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      di_valid_r  <= sq_valid[gvr_pkg::SQRT_STEPS];
      ri_valid_r  <= dv_valid[gvr_pkg::DIV_STEPS];
      out_valid_r <= rc_valid[gvr_pkg::RECIP_STEPS];
    end
  end

  always_comb begin
    s1_nxt        = '0;
    s1_nxt.aneg   = s0_a_r[DW-1];
    s1_nxt.bneg   = s0_b_r[DW-1];
    s1_nxt.amag   = s0_a_r[DW-1] ? (DW'(0) - s0_a_r) : s0_a_r;
    s1_nxt.bmag   = s0_b_r[DW-1] ? (DW'(0) - s0_b_r) : s0_b_r;
    s1_nxt.zero   = (s0_a_r == '0) && (s0_b_r == '0);
    s1_nxt.a_gt_b = s1_nxt.amag > s1_nxt.bmag;
    s1_nxt.sq_bits = gvr_pkg::SUM_W'(s1_nxt.amag) * gvr_pkg::SUM_W'(s1_nxt.amag);
    s1_nxt.bsq     = gvr_pkg::SUM_W'(s1_nxt.bmag) * gvr_pkg::SUM_W'(s1_nxt.bmag);
  end

  always_comb begin
    s2_nxt         = s1_r;
    s2_nxt.sq_bits = s1_r.sq_bits + s1_r.bsq;
    s2_nxt.sq_rem  = '0;
    s2_nxt.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a_r <= in_a_value;
      s0_b_r <= in_b_value;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      di_r   <= di_nxt;
      ri_r   <= ri_nxt;
      radius_r <= radius_nxt;
      cos_r    <= cos_nxt;
      sin_r    <= sin_nxt;
      z_r      <= z_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign sq_item[0]  = s2_r;
  assign sq_valid[0] = s2_valid_r;

  for (genvar i = 0; i < gvr_pkg::SQRT_STEPS; i++) begin : g_sqrt
    gvr_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_valid[i]),
      .in_item   (sq_item[i]),
      .out_valid (sq_valid[i+1]),
      .out_item  (sq_item[i+1])
    );
  end

  // Division setup: signs and the integer quotient bit (a magnitude never
  // exceeds the radius).
  always_comb begin
    di_nxt = sq_item[gvr_pkg::SQRT_STEPS];
    if (di_nxt.root == '0) begin
      di_nxt.root = DW'(1);
    end
    di_nxt.rneg = di_nxt.a_gt_b ? di_nxt.aneg : di_nxt.bneg;
    di_nxt.cneg = di_nxt.aneg ^ di_nxt.rneg;
    di_nxt.sneg = di_nxt.bneg ^ di_nxt.rneg;
    if (di_nxt.amag >= di_nxt.root) begin
      di_nxt.c_rem = di_nxt.amag - di_nxt.root;
      di_nxt.c_q   = gvr_pkg::CQ_W'(1);
    end else begin
      di_nxt.c_rem = di_nxt.amag;
      di_nxt.c_q   = '0;
    end
    if (di_nxt.bmag >= di_nxt.root) begin
      di_nxt.s_rem = di_nxt.bmag - di_nxt.root;
      di_nxt.s_q   = gvr_pkg::CQ_W'(1);
    end else begin
      di_nxt.s_rem = di_nxt.bmag;
      di_nxt.s_q   = '0;
    end
  end

  assign dv_item[0]  = di_r;
  assign dv_valid[0] = di_valid_r;

  for (genvar i = 0; i < gvr_pkg::DIV_STEPS; i++) begin : g_div
    gvr_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_valid[i]),
      .in_item   (dv_item[i]),
      .out_valid (dv_valid[i+1]),
      .out_item  (dv_item[i+1])
    );
  end

  // Reciprocal setup: the dividend is a single one followed by zeros, so the
  // first step starts from a remainder of one.
  always_comb begin
    ri_nxt          = dv_item[gvr_pkg::DIV_STEPS];
    ri_nxt.z_from_s = ri_nxt.a_gt_b;
    ri_nxt.z_one    = (ri_nxt.c_q == '0);
    if (ri_nxt.c_q <= gvr_pkg::CQ_W'(1)) begin
      ri_nxt.z_rem = gvr_pkg::CQ_W'(1) - ri_nxt.c_q;
      ri_nxt.z_q   = gvr_pkg::RQ_W'(1);
    end else begin
      ri_nxt.z_rem = gvr_pkg::CQ_W'(1);
      ri_nxt.z_q   = '0;
    end
  end

  assign rc_item[0]  = ri_r;
  assign rc_valid[0] = ri_valid_r;

  for (genvar i = 0; i < gvr_pkg::RECIP_STEPS; i++) begin : g_recip
    gvr_recip_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (rc_valid[i]),
      .in_item   (rc_item[i]),
      .out_valid (rc_valid[i+1]),
      .out_item  (rc_item[i+1])
    );
  end

  assign fin    = rc_item[gvr_pkg::RECIP_STEPS];
  assign posmax = gvr_pkg::ZW'({(DW-1){1'b1}});

  always_comb begin
    if (fin.z_from_s) begin
      zmag = gvr_pkg::ZW'(fin.s_q >> (gvr_pkg::TRIG_FRAC - gvr_pkg::FRAC_BITS));
      zneg = fin.sneg;
    end else if (fin.z_one) begin
      zmag = gvr_pkg::ZW'(1) << gvr_pkg::FRAC_BITS;
      zneg = 1'b0;
    end else begin
      zmag = gvr_pkg::ZW'(fin.z_q);
      zneg = fin.cneg;
    end
    sat_nxt = 1'b0;
    if (!zneg && (zmag > posmax)) begin
      zmag    = posmax;
      sat_nxt = 1'b1;
    end
    if (zneg && (zmag > posmax + gvr_pkg::ZW'(1))) begin
      zmag    = posmax + gvr_pkg::ZW'(1);
      sat_nxt = 1'b1;
    end
    z_nxt      = zneg ? (DW'(0) - DW'(zmag)) : DW'(zmag);
    radius_nxt = fin.rneg ? ((DW+1)'(0) - {1'b0, fin.root}) : {1'b0, fin.root};
    cos_nxt    = fin.cneg ? (gvr_pkg::TRIG_W'(0) - {1'b0, fin.c_q}) : {1'b0, fin.c_q};
    sin_nxt    = fin.sneg ? (gvr_pkg::TRIG_W'(0) - {1'b0, fin.s_q}) : {1'b0, fin.s_q};
    if (fin.zero) begin
      radius_nxt = '0;
      cos_nxt    = gvr_pkg::TRIG_W'(1) << gvr_pkg::TRIG_FRAC;
      sin_nxt    = '0;
      z_nxt      = '0;
      sat_nxt    = 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_radius      = radius_r;
  assign out_cos_val     = cos_r;
  assign out_sin_val     = sin_r;
  assign out_recon_z     = z_r;
  assign out_z_saturated = sat_r;

  a_stall_only_on_block : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_cos_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_cos_val <= $signed(33'sd1073741824)) &&
                   (out_cos_val >= $signed(-33'sd1073741824))))
    else $error("cosine outside unit range");

  a_not_both_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_cos_val != '0) || (out_sin_val != '0)))
    else $error("cosine and sine both zero");

  a_sat_extreme : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_z_saturated) |->
      ((out_recon_z == {1'b0, {(DW-1){1'b1}}}) || (out_recon_z == {1'b1, {(DW-1){1'b0}}})))
    else $error("saturated z is not at a range limit");

endmodule

>>> verif/givens_rotation_generate_tb.sv
// ----------------------------------------------------------------------------
// givens_rotation_generate_tb
// Streams (a, b) pairs through the rotation generator under several idling
// and stall patterns. Each result is checked field by field against an
// in-bench computation of the radius, cosine, sine and reconstruction value.
// ----------------------------------------------------------------------------
module givens_rotation_generate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = gvr_pkg::DATA_WIDTH;
  localparam int FRAC_BITS  = gvr_pkg::FRAC_BITS;
  localparam int TRIG_FRAC  = gvr_pkg::TRIG_FRAC;
  localparam int TRIG_W     = gvr_pkg::TRIG_W;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } pair_t;

  typedef struct packed {
    logic [DATA_WIDTH:0]   radius;
    logic [TRIG_W-1:0]     cos_val;
    logic [TRIG_W-1:0]     sin_val;
    logic [DATA_WIDTH-1:0] recon_z;
    logic                  z_sat;
  } rotation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DATA_WIDTH-1:0] in_a_value = '0;
  logic signed [DATA_WIDTH-1:0] in_b_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_WIDTH:0]   out_radius;
  logic signed [TRIG_W-1:0]     out_cos_val;
  logic signed [TRIG_W-1:0]     out_sin_val;
  logic signed [DATA_WIDTH-1:0] out_recon_z;
  logic out_z_saturated;

  pair_t     pending_pairs[$];
  rotation_t expected_rotations[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold = 1'b0;
  int hold_cycles = 0;
  int errors = 0;

  givens_rotation_generate dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rotation_t calc_rotation(logic [DATA_WIDTH-1:0] a,
                                              logic [DATA_WIDTH-1:0] b);
    rotation_t res;
    logic [63:0] amag, bmag, rmag, cmag, smag, zmag, rem, cand, posmax;
    logic [127:0] sum;
    logic aneg, bneg, rneg, cneg, sneg, zneg, sat;
    aneg = a[DATA_WIDTH-1];
    bneg = b[DATA_WIDTH-1];
    amag = aneg ? {32'd0, -a} : {32'd0, a};
    bmag = bneg ? {32'd0, -b} : {32'd0, b};
    sat = 1'b0;
    if (amag == 0 && bmag == 0) begin
      res = '0;
      res.cos_val = 32'd1 << TRIG_FRAC;
      return res;
    end
    sum = 128'(amag) * 128'(amag) + 128'(bmag) * 128'(bmag);
    rmag = 0;
    for (int i = DATA_WIDTH; i >= 0; i--) begin
      cand = rmag | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= sum) rmag = cand;
    end
    if (rmag == 0) rmag = 1;
    rneg = (amag > bmag) ? aneg : bneg;
    // Restoring division, one quotient bit per step, numerator <= divisor.
    rem = amag;
    cmag = 0;
    if (rem >= rmag) begin rem -= rmag; cmag = 1; end
    for (int i = 0; i < TRIG_FRAC; i++) begin
      rem = rem << 1;
      cmag = cmag << 1;
      if (rem >= rmag) begin rem -= rmag; cmag |= 1; end
    end
    rem = bmag;
    smag = 0;
    if (rem >= rmag) begin rem -= rmag; smag = 1; end
    for (int i = 0; i < TRIG_FRAC; i++) begin
      rem = rem << 1;
      smag = smag << 1;
      if (rem >= rmag) begin rem -= rmag; smag |= 1; end
    end
    cneg = aneg != rneg;
    sneg = bneg != rneg;
    if (amag > bmag) begin
      zmag = smag >> (TRIG_FRAC - FRAC_BITS);
      zneg = sneg;
    end else if (cmag != 0) begin
      zmag = (64'd1 << (FRAC_BITS + TRIG_FRAC)) / cmag;
      zneg = cneg;
    end else begin
      zmag = 64'd1 << FRAC_BITS;
      zneg = 1'b0;
    end
    posmax = (64'd1 << (DATA_WIDTH - 1)) - 1;
    if (!zneg && zmag > posmax) begin zmag = posmax; sat = 1'b1; end
    if (zneg && zmag > posmax + 1) begin zmag = posmax + 1; sat = 1'b1; end
    res.radius  = rneg ? -rmag[DATA_WIDTH:0] : rmag[DATA_WIDTH:0];
    res.cos_val = cneg ? -cmag[TRIG_W-1:0] : cmag[TRIG_W-1:0];
    res.sin_val = sneg ? -smag[TRIG_W-1:0] : smag[TRIG_W-1:0];
    res.recon_z = zneg ? -zmag[DATA_WIDTH-1:0] : zmag[DATA_WIDTH-1:0];
    res.z_sat   = sat;
    return res;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_component();
    unique case ($urandom_range(5))
      0: return '0;
      1: return $urandom_range(255) - 128;
      2: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      3: return {$urandom_range(1) ? 1'b1 : 1'b0, {(DATA_WIDTH-1){1'b1}}} ^
                $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Driver: a new item is offered only once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_rotations.push_back(calc_rotation(in_a_value, in_b_value));
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_a_value <= pending_pairs[0].a;
          in_b_value <= pending_pairs[0].b;
          void'(pending_pairs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off that backs the pipeline up.
  always @(posedge clk) begin
    if (long_hold && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    rotation_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rotations.size() == 0) begin
        $display("%0t: unexpected result radius=%h", $time, out_radius);
        errors++;
      end else begin
        exp_r = expected_rotations.pop_front();
        if (out_radius !== exp_r.radius) begin
          $display("%0t: radius expected %h actual %h", $time, exp_r.radius, out_radius);
          errors++;
        end
        if (out_cos_val !== exp_r.cos_val) begin
          $display("%0t: cos expected %h actual %h", $time, exp_r.cos_val, out_cos_val);
          errors++;
        end
        if (out_sin_val !== exp_r.sin_val) begin
          $display("%0t: sin expected %h actual %h", $time, exp_r.sin_val, out_sin_val);
          errors++;
        end
        if (out_recon_z !== exp_r.recon_z) begin
          $display("%0t: z expected %h actual %h", $time, exp_r.recon_z, out_recon_z);
          errors++;
        end
        if (out_z_saturated !== exp_r.z_sat) begin
          $display("%0t: z_saturated expected %b actual %b", $time, exp_r.z_sat,
                   out_z_saturated);
          errors++;
        end
      end
    end
  end

  task automatic add_pair(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    pair_t p;
    p.a = a;
    p.b = b;
    pending_pairs.push_back(p);
  endtask

  // Sender pauses here until every expected result has come back.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_rotations.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) add_pair(rand_component(), rand_component());
    drain();
  endtask

  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Zero pair, extremes, equal magnitudes, a zero cosine and tiny cosines.
    add_pair('0, '0);
    add_pair(MAXV, MAXV);
    add_pair(MINV, MINV);
    add_pair(MINV, MAXV);
    add_pair(MAXV, MINV);
    add_pair(MINV, '0);
    add_pair('0, MINV);
    add_pair('0, 32'd1);
    add_pair('0, -32'sd1);
    add_pair(32'd1, '0);
    add_pair(-32'sd1, '0);
    add_pair(32'd1, MAXV);
    add_pair(-32'sd1, MINV);
    add_pair(32'd1, MINV);
    add_pair(32'h0001_0000, 32'h0001_0000);
    add_pair(32'h0001_0000, -32'sh0001_0000);
    add_pair(32'h0003_0000, 32'h0004_0000);
    add_pair(-32'sh0004_0000, 32'h0003_0000);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);
    run_phase(0, 0, 250);
    run_phase(68, 0, 250);
    run_phase(0, 68, 250);
    run_phase(8, 8, 250);
    long_hold = 1'b1;
    run_phase(0, 0, 230);
    repeat (150) @(posedge clk);
    if (errors == 0)
      $display("givens_rotation_generate verification clean");
    else
      $display("givens_rotation_generate verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("givens_rotation_generate verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/gvr_pkg.sv
rtl/gvr_sqrt_cell.sv
rtl/gvr_div_cell.sv
rtl/gvr_recip_cell.sv
rtl/givens_rotation_generate.sv
verif/givens_rotation_generate_tb.sv
